/* rtl/cbdc_pkg.sv */
// Shared types and constants of the capped bin draw compactor.
package cbdc_pkg;

   localparam int RECORDS_DEFAULT = 64;
   localparam int BINS_DEFAULT    = 16;

   localparam int BIN_W   = 16;
   localparam int TAG_W   = 32;
   localparam int CAP_W   = 5;
   localparam int POS_W   = 7;
   localparam int CSR_W   = 7;
   localparam int CSR_IDX_W = 1;

   // At most this many bins can be in use (bin_capacity is five bits).
   localparam int MAX_USED_BINS = 31;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
   localparam logic [POS_W-1:0] MV_RESET  = 7'd64;

   localparam logic [CSR_IDX_W-1:0] CSR_BIN_CAPACITY = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_VISIBLE  = 1'd1;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_FETCH = 1'b1;

   typedef enum logic [1:0] {
      KIND_VISIBLE  = 2'd0,
      KIND_OVERFLOW = 2'd1,
      KIND_SUMMARY  = 2'd2,
      KIND_TOTALS   = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_START,
      ST_COUNT,
      ST_PREFIX,
      ST_SCAT_INIT,
      ST_SCATTER,
      ST_DRAIN,
      ST_ORDER,
      ST_REC,
      ST_EMIT
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_START,
      OP_COUNT,
      OP_PREFIX,
      OP_SCAT_INIT,
      OP_SCATTER,
      OP_READ,
      OP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic prefix_done;
      logic rsp_free;
      logic is_totals;
   } dp_status_type;

endpackage

/* rtl/cbdc_ram.sv */
// Generic simple dual-port RAM with registered read.
module cbdc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

/* rtl/cbdc_ctrl.sv */
// Controller state machine of the compactor.
module cbdc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_cmd,
   output logic                   req_ready,
   input  cbdc_pkg::dp_status_type status,
   output cbdc_pkg::ctrl_cmd_type  cmd
);

   cbdc_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cbdc_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd.op    = cbdc_pkg::OP_NONE;
      unique case (state_ff)
         cbdc_pkg::ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_cmd == cbdc_pkg::CMD_FETCH) begin
                  cmd.op   = cbdc_pkg::OP_START;
                  state_in = cbdc_pkg::ST_COUNT;
               end else begin
                  cmd.op = cbdc_pkg::OP_LOAD;
               end
            end
         end
         cbdc_pkg::ST_START: begin
            cmd.op   = cbdc_pkg::OP_START;
            state_in = cbdc_pkg::ST_COUNT;
         end
         cbdc_pkg::ST_COUNT: begin
            cmd.op = cbdc_pkg::OP_COUNT;
            if (status.scan_done) begin
               state_in = cbdc_pkg::ST_PREFIX;
            end
         end
         cbdc_pkg::ST_PREFIX: begin
            cmd.op = cbdc_pkg::OP_PREFIX;
            if (status.prefix_done) begin
               state_in = cbdc_pkg::ST_SCAT_INIT;
            end
         end
         cbdc_pkg::ST_SCAT_INIT: begin
            cmd.op   = cbdc_pkg::OP_SCAT_INIT;
            state_in = cbdc_pkg::ST_SCATTER;
         end
         cbdc_pkg::ST_SCATTER: begin
            cmd.op = cbdc_pkg::OP_SCATTER;
            if (status.scan_done) begin
               state_in = cbdc_pkg::ST_ORDER;
            end
         end
         cbdc_pkg::ST_DRAIN: begin
            req_ready = 1'b1;
            if (req_valid && (req_cmd == cbdc_pkg::CMD_FETCH)) begin
               state_in = cbdc_pkg::ST_ORDER;
            end
         end
         cbdc_pkg::ST_ORDER: begin
            cmd.op   = cbdc_pkg::OP_READ;
            state_in = cbdc_pkg::ST_REC;
         end
         cbdc_pkg::ST_REC: begin
            cmd.op   = cbdc_pkg::OP_READ;
            state_in = cbdc_pkg::ST_EMIT;
         end
         cbdc_pkg::ST_EMIT: begin
            cmd.op = cbdc_pkg::OP_READ;
            if (status.rsp_free) begin
               cmd.op   = cbdc_pkg::OP_EMIT;
               state_in = status.is_totals ? cbdc_pkg::ST_LOAD : cbdc_pkg::ST_DRAIN;
            end
         end
         default: state_in = cbdc_pkg::ST_LOAD;
      endcase
   end

endmodule

/* rtl/cbdc_datapath.sv */
// Datapath: record store, per-bin tables, order stores, result register.
module cbdc_datapath #(
   parameter int RECORDS = cbdc_pkg::RECORDS_DEFAULT,
   parameter int BINS    = cbdc_pkg::BINS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  cbdc_pkg::ctrl_cmd_type              cmd,
   output cbdc_pkg::dp_status_type             status,
   input  logic [cbdc_pkg::BIN_W-1:0]          req_draw_bin,
   input  logic [cbdc_pkg::TAG_W-1:0]          req_draw_tag,
   input  logic                                csr_wr_en,
   input  logic [cbdc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cbdc_pkg::CSR_W-1:0]          csr_wdata,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_kind,
   output logic [cbdc_pkg::BIN_W-1:0]          rsp_bin,
   output logic [cbdc_pkg::TAG_W-1:0]          rsp_tag,
   output logic [cbdc_pkg::POS_W-1:0]          rsp_position,
   output logic [cbdc_pkg::POS_W-1:0]          rsp_retained,
   output logic [cbdc_pkg::POS_W-1:0]          rsp_candidates,
   output logic [cbdc_pkg::CAP_W-1:0]          rsp_nonempty_bins,
   output logic [cbdc_pkg::POS_W-1:0]          rsp_overflow_total,
   output logic                                rsp_lost,
   output logic                                rsp_last
);

   localparam int NB  = (BINS < cbdc_pkg::MAX_USED_BINS) ? BINS : cbdc_pkg::MAX_USED_BINS;
   localparam int BW  = (NB > 1) ? $clog2(NB) : 1;
   localparam int IW  = (RECORDS > 1) ? $clog2(RECORDS) : 1;
   localparam int CNW = $clog2(RECORDS + 1);
   localparam int KW  = (CNW > cbdc_pkg::POS_W) ? CNW : cbdc_pkg::POS_W;
   localparam int CW0 = $clog2(RECORDS + cbdc_pkg::MAX_USED_BINS + 2);
   localparam int CW  = (CW0 > 8) ? CW0 : 8;
   localparam int PW  = cbdc_pkg::POS_W;

   // configuration
   logic [cbdc_pkg::CAP_W-1:0] cap_ff;
   logic [PW-1:0]              mv_ff;

   // set state
   logic [CNW-1:0]             rec_cnt_ff, rec_cnt_in;
   logic                       dropped_ff, dropped_in;
   logic [cbdc_pkg::CAP_W-1:0] used_ff, used_in;
   logic [PW-1:0]              lim_mv_ff, lim_mv_in;
   logic [CNW-1:0]             scan_idx_ff, scan_idx_in;
   logic                       pend_ff, pend_in;
   logic [IW-1:0]              pidx_ff, pidx_in;
   logic [CNW-1:0]             cnt_ff [NB];
   logic [CNW-1:0]             cnt_in [NB];
   logic [PW-1:0]              offs_ff [NB];
   logic [PW-1:0]              offs_in [NB];
   logic [PW-1:0]              wp_ff [NB];
   logic [PW-1:0]              wp_in [NB];
   logic [PW-1:0]              limit_ff [NB];
   logic [PW-1:0]              limit_in [NB];
   logic [cbdc_pkg::CAP_W-1:0] pb_ff, pb_in;
   logic [PW-1:0]              run_ff, run_in;
   logic [cbdc_pkg::CAP_W-1:0] active_ff, active_in;
   logic [CNW-1:0]             ovf_ff, ovf_in;
   logic [CW-1:0]              cur_ff, cur_in;

   // result register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [1:0]                 kind_ff, kind_in;
   logic [cbdc_pkg::BIN_W-1:0] bin_ff, bin_in;
   logic [cbdc_pkg::TAG_W-1:0] tag_ff, tag_in;
   logic [PW-1:0]              pos_ff, pos_in;
   logic [PW-1:0]              ret_ff, ret_in;
   logic [PW-1:0]              cand_ff, cand_in;
   logic [cbdc_pkg::CAP_W-1:0] act_ff, act_in;
   logic [PW-1:0]              ovt_ff, ovt_in;
   logic                       lost_ff, lost_in;
   logic                       last_ff, last_in;

   // memory ports
   logic                       st_we;
   logic [IW-1:0]              st_raddr;
   logic [cbdc_pkg::BIN_W-1:0] st_bin_rd;
   logic [cbdc_pkg::TAG_W-1:0] st_tag_rd;
   logic                       vis_we;
   logic [IW-1:0]              vis_waddr;
   logic [IW-1:0]              vis_rd;
   logic                       ovo_we;
   logic [IW-1:0]              ovo_rd;

   // helpers
   logic                       scanning;
   logic                       in_range;
   logic [BW-1:0]              bx;
   logic [BW-1:0]              px;
   logic [PW-1:0]              room;
   logic [PW-1:0]              keep;
   logic [CW-1:0]              d1;
   logic [CW-1:0]              d2;
   logic [BW-1:0]              sb;
   cbdc_pkg::kind_type         cat;

   cbdc_ram #(.WIDTH(cbdc_pkg::BIN_W), .DEPTH(RECORDS), .AW(IW)) u_bin_ram (
      .clock      (clock),
      .wr_en      (st_we),
      .wr_addr    (rec_cnt_ff[IW-1:0]),
      .wr_data    (req_draw_bin),
      .rd_addr    (st_raddr),
      .rd_data_ff (st_bin_rd)
   );

   cbdc_ram #(.WIDTH(cbdc_pkg::TAG_W), .DEPTH(RECORDS), .AW(IW)) u_tag_ram (
      .clock      (clock),
      .wr_en      (st_we),
      .wr_addr    (rec_cnt_ff[IW-1:0]),
      .wr_data    (req_draw_tag),
      .rd_addr    (st_raddr),
      .rd_data_ff (st_tag_rd)
   );

   cbdc_ram #(.WIDTH(IW), .DEPTH(RECORDS), .AW(IW)) u_vis_ram (
      .clock      (clock),
      .wr_en      (vis_we),
      .wr_addr    (vis_waddr),
      .wr_data    (pidx_ff),
      .rd_addr    (IW'(cur_ff)),
      .rd_data_ff (vis_rd)
   );

   cbdc_ram #(.WIDTH(IW), .DEPTH(RECORDS), .AW(IW)) u_ovf_ram (
      .clock      (clock),
      .wr_en      (ovo_we),
      .wr_addr    (ovf_ff[IW-1:0]),
      .wr_data    (pidx_ff),
      .rd_addr    (IW'(d1)),
      .rd_data_ff (ovo_rd)
   );

   // drain cursor decode
   assign d1 = cur_ff - CW'(run_ff);
   assign d2 = d1 - CW'(ovf_ff);
   assign sb = d2[BW-1:0];

   always_comb begin
      if (cur_ff < CW'(run_ff)) begin
         cat = cbdc_pkg::KIND_VISIBLE;
      end else if (d1 < CW'(ovf_ff)) begin
         cat = cbdc_pkg::KIND_OVERFLOW;
      end else if (d2 < CW'(used_ff)) begin
         cat = cbdc_pkg::KIND_SUMMARY;
      end else begin
         cat = cbdc_pkg::KIND_TOTALS;
      end
   end

   assign scanning = (cmd.op == cbdc_pkg::OP_COUNT) || (cmd.op == cbdc_pkg::OP_SCATTER);
   assign st_raddr = scanning ? scan_idx_ff[IW-1:0]
                   : ((cat == cbdc_pkg::KIND_VISIBLE) ? vis_rd : ovo_rd);
   assign in_range = st_bin_rd < cbdc_pkg::BIN_W'(used_ff);
   assign bx       = st_bin_rd[BW-1:0];
   assign px       = pb_ff[BW-1:0];
   assign room     = (lim_mv_ff > run_ff) ? (lim_mv_ff - run_ff) : '0;
   assign keep     = (KW'(cnt_ff[px]) < KW'(room)) ? PW'(cnt_ff[px]) : room;
   assign vis_waddr = IW'(wp_ff[bx]);

   assign status.scan_done   = (scan_idx_ff == rec_cnt_ff) && !pend_ff;
   assign status.prefix_done = (pb_ff == used_ff);
   assign status.rsp_free    = !rsp_valid_ff || rsp_ready;
   assign status.is_totals   = (cat == cbdc_pkg::KIND_TOTALS);

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= cbdc_pkg::CAP_RESET;
         mv_ff  <= cbdc_pkg::MV_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            cbdc_pkg::CSR_BIN_CAPACITY: cap_ff <= csr_wdata[cbdc_pkg::CAP_W-1:0];
            cbdc_pkg::CSR_MAX_VISIBLE:  mv_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      rec_cnt_in   = rec_cnt_ff;
      dropped_in   = dropped_ff;
      used_in      = used_ff;
      lim_mv_in    = lim_mv_ff;
      scan_idx_in  = scan_idx_ff;
      pend_in      = pend_ff;
      pidx_in      = pidx_ff;
      cnt_in       = cnt_ff;
      offs_in      = offs_ff;
      wp_in        = wp_ff;
      limit_in     = limit_ff;
      pb_in        = pb_ff;
      run_in       = run_ff;
      active_in    = active_ff;
      ovf_in       = ovf_ff;
      cur_in       = cur_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      kind_in      = kind_ff;
      bin_in       = bin_ff;
      tag_in       = tag_ff;
      pos_in       = pos_ff;
      ret_in       = ret_ff;
      cand_in      = cand_ff;
      act_in       = act_ff;
      ovt_in       = ovt_ff;
      lost_in      = lost_ff;
      last_in      = last_ff;
      st_we        = 1'b0;
      vis_we       = 1'b0;
      ovo_we       = 1'b0;

      // record fetch shared by the count and scatter sweeps
      if (scanning) begin
         if (scan_idx_ff < rec_cnt_ff) begin
            scan_idx_in = scan_idx_ff + 1'b1;
            pend_in     = 1'b1;
            pidx_in     = scan_idx_ff[IW-1:0];
         end else begin
            pend_in = 1'b0;
         end
      end

      unique case (cmd.op)
         cbdc_pkg::OP_LOAD: begin
            if (rec_cnt_ff == CNW'(RECORDS)) begin
               dropped_in = 1'b1;
            end else begin
               st_we      = 1'b1;
               rec_cnt_in = rec_cnt_ff + 1'b1;
            end
         end
         cbdc_pkg::OP_START: begin
            for (int b = 0; b < NB; b++) begin
               cnt_in[b] = '0;
            end
            used_in     = (cap_ff > cbdc_pkg::CAP_W'(NB)) ? cbdc_pkg::CAP_W'(NB) : cap_ff;
            lim_mv_in   = mv_ff;
            scan_idx_in = '0;
            pend_in     = 1'b0;
            pb_in       = '0;
            run_in      = '0;
            active_in   = '0;
            ovf_in      = '0;
            cur_in      = '0;
         end
         cbdc_pkg::OP_COUNT: begin
            if (pend_ff) begin
               if (in_range) begin
                  cnt_in[bx] = cnt_ff[bx] + 1'b1;
               end else begin
                  ovo_we = 1'b1;
                  ovf_in = ovf_ff + 1'b1;
               end
            end
         end
         cbdc_pkg::OP_PREFIX: begin
            if (pb_ff < used_ff) begin
               offs_in[px]  = run_ff;
               wp_in[px]    = run_ff;
               limit_in[px] = run_ff + keep;
               if (cnt_ff[px] != '0) begin
                  active_in = active_ff + 1'b1;
               end
               run_in     = run_ff + keep;
               cnt_in[px] = '0;
               pb_in      = pb_ff + 1'b1;
            end
         end
         cbdc_pkg::OP_SCAT_INIT: begin
            scan_idx_in = '0;
            pend_in     = 1'b0;
         end
         cbdc_pkg::OP_SCATTER: begin
            if (pend_ff && in_range) begin
               if (wp_ff[bx] >= limit_ff[bx]) begin
                  ovo_we = 1'b1;
                  ovf_in = ovf_ff + 1'b1;
               end else begin
                  vis_we     = 1'b1;
                  wp_in[bx]  = wp_ff[bx] + 1'b1;
                  cnt_in[bx] = cnt_ff[bx] + 1'b1;
               end
            end
         end
         cbdc_pkg::OP_EMIT: begin
            rsp_valid_in = 1'b1;
            kind_in      = cat;
            bin_in       = '0;
            tag_in       = '0;
            pos_in       = '0;
            ret_in       = '0;
            cand_in      = '0;
            act_in       = '0;
            ovt_in       = '0;
            lost_in      = 1'b0;
            last_in      = 1'b0;
            cur_in       = cur_ff + 1'b1;
            case (cat)
               cbdc_pkg::KIND_VISIBLE: begin
                  bin_in = st_bin_rd;
                  tag_in = st_tag_rd;
                  pos_in = PW'(cur_ff);
               end
               cbdc_pkg::KIND_OVERFLOW: begin
                  bin_in = st_bin_rd;
                  tag_in = st_tag_rd;
               end
               cbdc_pkg::KIND_SUMMARY: begin
                  bin_in = cbdc_pkg::BIN_W'(d2);
                  pos_in = offs_ff[sb];
                  ret_in = PW'(cnt_ff[sb]);
               end
               default: begin
                  ret_in     = run_ff;
                  cand_in    = PW'(rec_cnt_ff);
                  act_in     = active_ff;
                  ovt_in     = PW'(ovf_ff);
                  lost_in    = dropped_ff;
                  last_in    = 1'b1;
                  rec_cnt_in = '0;
                  dropped_in = 1'b0;
               end
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_cnt_ff   <= '0;
         dropped_ff   <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         used_ff      <= '0;
         lim_mv_ff    <= '0;
         scan_idx_ff  <= '0;
         pb_ff        <= '0;
         run_ff       <= '0;
         active_ff    <= '0;
         ovf_ff       <= '0;
         cur_ff       <= '0;
      end else begin
         rec_cnt_ff   <= rec_cnt_in;
         dropped_ff   <= dropped_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         used_ff      <= used_in;
         lim_mv_ff    <= lim_mv_in;
         scan_idx_ff  <= scan_idx_in;
         pb_ff        <= pb_in;
         run_ff       <= run_in;
         active_ff    <= active_in;
         ovf_ff       <= ovf_in;
         cur_ff       <= cur_in;
      end
   end

   always_ff @(posedge clock) begin
      pidx_ff  <= pidx_in;
      cnt_ff   <= cnt_in;
      offs_ff  <= offs_in;
      wp_ff    <= wp_in;
      limit_ff <= limit_in;
      kind_ff  <= kind_in;
      bin_ff   <= bin_in;
      tag_ff   <= tag_in;
      pos_ff   <= pos_in;
      ret_ff   <= ret_in;
      cand_ff  <= cand_in;
      act_ff   <= act_in;
      ovt_ff   <= ovt_in;
      lost_ff  <= lost_in;
      last_ff  <= last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = kind_ff;
   assign rsp_bin            = bin_ff;
   assign rsp_tag            = tag_ff;
   assign rsp_position       = pos_ff;
   assign rsp_retained       = ret_ff;
   assign rsp_candidates     = cand_ff;
   assign rsp_nonempty_bins  = act_ff;
   assign rsp_overflow_total = ovt_ff;
   assign rsp_lost           = lost_ff;
   assign rsp_last           = last_ff;

endmodule

/* rtl/capped_bin_draw_compactor.sv */
// Top level of the capped bin draw compactor: controller plus datapath.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_ready   cmd, draw_bin, draw_tag
//   rsp      out        rsp_valid/rsp_ready   kind .. last (ten fields)
//   csr      in         csr_wr_en             csr_index, csr_wdata
//
// A load transfer gives no result. The first fetch of a set then runs a
// count sweep over the records, a prefix pass over the bins in use, a
// scatter setup step and a scatter sweep, the sweeps on the record RAM read
// port. After that, and for every later fetch, come an order RAM read, a
// record RAM read and the output register write; a new fetch is accepted
// only once the previous result is written. Reset is synchronous; no
// clearing pass is needed. A waiting result holds the block only at the
// point where the next result must be written.
module capped_bin_draw_compactor #(
   parameter int RECORDS = cbdc_pkg::RECORDS_DEFAULT,
   parameter int BINS    = cbdc_pkg::BINS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_cmd,
   input  logic [cbdc_pkg::BIN_W-1:0]     req_draw_bin,
   input  logic [cbdc_pkg::TAG_W-1:0]     req_draw_tag,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [1:0]                     rsp_kind,
   output logic [cbdc_pkg::BIN_W-1:0]     rsp_bin,
   output logic [cbdc_pkg::TAG_W-1:0]     rsp_tag,
   output logic [cbdc_pkg::POS_W-1:0]     rsp_position,
   output logic [cbdc_pkg::POS_W-1:0]     rsp_retained,
   output logic [cbdc_pkg::POS_W-1:0]     rsp_candidates,
   output logic [cbdc_pkg::CAP_W-1:0]     rsp_nonempty_bins,
   output logic [cbdc_pkg::POS_W-1:0]     rsp_overflow_total,
   output logic                           rsp_lost,
   output logic                           rsp_last,
   input  logic                           csr_wr_en,
   input  logic [cbdc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cbdc_pkg::CSR_W-1:0]     csr_wdata
);

   // controller drives one datapath op per cycle and watches its status
   cbdc_pkg::ctrl_cmd_type  cmd;
   cbdc_pkg::dp_status_type status;

   cbdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   cbdc_datapath #(.RECORDS(RECORDS), .BINS(BINS)) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_draw_bin       (req_draw_bin),
      .req_draw_tag       (req_draw_tag),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_bin            (rsp_bin),
      .rsp_tag            (rsp_tag),
      .rsp_position       (rsp_position),
      .rsp_retained       (rsp_retained),
      .rsp_candidates     (rsp_candidates),
      .rsp_nonempty_bins  (rsp_nonempty_bins),
      .rsp_overflow_total (rsp_overflow_total),
      .rsp_lost           (rsp_lost),
      .rsp_last           (rsp_last)
   );

endmodule
